[hdl/rle_register_patch_loader_top_defines.svh]
// assertion macros for the patch loader
`ifndef RLE_REGISTER_PATCH_LOADER_TOP_DEFINES_SVH
`define RLE_REGISTER_PATCH_LOADER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

`define RLEPL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rlepl assertion failed");

`define RLEPL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rlepl assertion failed");

`else

`define RLEPL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RLEPL_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[hdl/rlepl_pkg.sv]
// shared types and constants of the patch loader
`default_nettype none

package rlepl_pkg;

    localparam logic [15:0] RUN_FLAG   = 16'h8000;
    localparam logic [14:0] COUNT_MASK = 15'h7FFF;

    typedef enum logic
    {
        OP_WORD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    typedef enum logic
    {
        KIND_WRITE  = 1'b0,
        KIND_REJECT = 1'b1
    } kind_t;

    typedef struct packed
    {
        op_t         op;
        logic [15:0] word;
        logic        last;
    } item_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } q_status_t;

endpackage

`default_nettype wire

[hdl/rlepl_front.sv]
// front stage: accepts input transactions and classifies them
`default_nettype none

module rlepl_front
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          valid,
    output logic               ready,
    input  wire logic          mode,
    input  wire logic [15:0]   word,
    input  wire logic          last_word,
    output rlepl_pkg::item_t   item,
    output logic               item_valid,
    input  wire logic          item_ready
);
    import rlepl_pkg::*;

    item_t item_reg;
    item_t item_next;
    logic  valid_reg;
    logic  valid_next;
    logic  accept;

    assign ready  = !valid_reg || item_ready;
    assign accept = valid && ready;

    always_comb
    begin
        // a tick carries no word and no last flag
        if (mode)
        begin
            item_next.op   = OP_TICK;
            item_next.word = 16'd0;
            item_next.last = 1'b0;
        end
        else
        begin
            item_next.op   = OP_WORD;
            item_next.word = word;
            item_next.last = last_word;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (item_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

    assign item       = item_reg;
    assign item_valid = valid_reg;

endmodule

`default_nettype wire

[hdl/rlepl_queue.sv]
// short queue of classified items between front and back
`default_nettype none

module rlepl_queue
#(
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire rlepl_pkg::item_t  push_item,
    input  wire logic              push_valid,
    output logic                   push_ready,
    output rlepl_pkg::item_t       pop_item,
    output logic                   pop_valid,
    input  wire logic              pop_ready,
    output rlepl_pkg::q_status_t   status
);
    import rlepl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign push_ready   = !status.full;
    assign pop_valid    = !status.empty;
    assign pop_item     = mem_reg[rd_ptr_reg];
    assign do_push      = push_valid && push_ready;
    assign do_pop       = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

[hdl/rlepl_back.sv]
// back stage: record parser and registered result output
`default_nettype none

module rlepl_back
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire rlepl_pkg::item_t item,
    input  wire logic          item_valid,
    output logic               item_ready,
    output logic               valid,
    input  wire logic          ready,
    output logic               kind,
    output logic [7:0]         reg_address,
    output logic [15:0]        reg_value,
    output logic               record_end
);
    import rlepl_pkg::*;

    typedef enum logic [2:0]
    {
        PH_ADDR    = 3'd0,
        PH_COUNT   = 3'd1,
        PH_FILL    = 3'd2,
        PH_LITERAL = 3'd3,
        PH_REPEAT  = 3'd4
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  target_reg;
    logic [7:0]  target_next;
    logic [14:0] remaining_reg;
    logic [14:0] remaining_next;
    logic [15:0] fill_reg;
    logic [15:0] fill_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    kind_t       kind_reg;
    kind_t       kind_next;
    logic [15:0] value_reg;
    logic [15:0] value_next;
    logic        end_reg;
    logic        end_next;
    logic [7:0]  addr_reg;
    logic        take;
    logic        emit;
    logic [14:0] rem_dec;

    assign item_ready = !out_valid_reg || ready;
    assign take       = item_valid && item_ready;
    assign rem_dec    = remaining_reg - 15'd1;

    always_comb
    begin
        phase_next     = phase_reg;
        target_next    = target_reg;
        remaining_next = remaining_reg;
        fill_next      = fill_reg;
        emit           = 1'b0;
        kind_next      = KIND_WRITE;
        value_next     = fill_reg;
        end_next       = 1'b0;
        if (take)
        begin
            if (item.op == OP_TICK)
            begin
                if (phase_reg == PH_REPEAT)
                begin
                    if (remaining_reg != 15'd0)
                    begin
                        remaining_next = rem_dec;
                        emit           = 1'b1;
                        end_next       = (rem_dec == 15'd0);
                        if (rem_dec == 15'd0)
                        begin
                            phase_next = PH_ADDR;
                        end
                    end
                    else
                    begin
                        phase_next = PH_ADDR;
                    end
                end
            end
            else
            begin
                case (phase_reg)
                    PH_REPEAT:
                    begin
                        // word while a fill run is pending: flag it, keep state
                        emit       = 1'b1;
                        kind_next  = KIND_REJECT;
                        value_next = item.word;
                    end
                    PH_COUNT:
                    begin
                        remaining_next = item.word[14:0] & COUNT_MASK;
                        if ((item.word & RUN_FLAG) != 16'd0)
                        begin
                            phase_next = PH_FILL;
                        end
                        else if ((item.word[14:0] & COUNT_MASK) == 15'd0)
                        begin
                            phase_next = PH_ADDR;
                        end
                        else
                        begin
                            phase_next = PH_LITERAL;
                        end
                    end
                    PH_FILL:
                    begin
                        fill_next  = item.word;
                        phase_next = (remaining_reg == 15'd0) ? PH_ADDR : PH_REPEAT;
                    end
                    PH_LITERAL:
                    begin
                        remaining_next = rem_dec;
                        emit           = 1'b1;
                        value_next     = item.word;
                        end_next       = (rem_dec == 15'd0);
                        if (rem_dec == 15'd0)
                        begin
                            phase_next = PH_ADDR;
                        end
                    end
                    default:
                    begin
                        target_next = item.word[7:0];
                        phase_next  = PH_COUNT;
                    end
                endcase
                // last word resets the parser unless a fill run is pending
                if (item.last && (phase_next != PH_REPEAT))
                begin
                    phase_next = PH_ADDR;
                end
            end
        end
        if (take)
        begin
            out_valid_next = emit;
        end
        else if (ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_ADDR;
            target_reg    <= 8'd0;
            remaining_reg <= 15'd0;
            fill_reg      <= 16'd0;
            out_valid_reg <= 1'b0;
            kind_reg      <= KIND_WRITE;
            addr_reg      <= 8'd0;
            value_reg     <= 16'd0;
            end_reg       <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            target_reg    <= target_next;
            remaining_reg <= remaining_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
            if (take && emit)
            begin
                kind_reg  <= kind_next;
                addr_reg  <= target_reg;
                value_reg <= value_next;
                end_reg   <= end_next;
            end
        end
    end

    assign valid       = out_valid_reg;
    assign kind        = kind_reg;
    assign reg_address = addr_reg;
    assign reg_value   = value_reg;
    assign record_end  = end_reg;

endmodule

`default_nettype wire

[hdl/rle_register_patch_loader_top.sv]
// top level of the run-length register patch loader
`default_nettype none

`include "rle_register_patch_loader_top_defines.svh"

// Expands a stream of 16-bit patch words (address, count, then a fill word or
// literal words) into 8-bit-address register writes; fill runs are paid out
// one write per tick transaction. One transaction is accepted per clock cycle
// when the output is free; an accepted transaction passes the front register,
// then the queue, then the back parser register that holds its result. While a
// result waits at the output, the front register and the queue of QUEUE_DEPTH
// entries take QUEUE_DEPTH + 1 further transactions before the input is held
// off; the parser update with its one 15-bit decrement is the step that sets
// the rate.
module rle_register_patch_loader_top
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         mode,
    input  wire logic [15:0]  word,
    input  wire logic         last_word,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic              kind,
    output logic [7:0]        reg_address,
    output logic [15:0]       reg_value,
    output logic              record_end
);
    import rlepl_pkg::*;

    item_t     front_item;
    logic      front_valid;
    logic      front_ready;
    item_t     back_item;
    logic      back_valid;
    logic      back_ready;
    q_status_t q_status;

    rlepl_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .valid      (in_valid),
        .ready      (in_ready),
        .mode       (mode),
        .word       (word),
        .last_word  (last_word),
        .item       (front_item),
        .item_valid (front_valid),
        .item_ready (front_ready)
    );

    rlepl_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_item  (front_item),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_item   (back_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .status     (q_status)
    );

    rlepl_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .item        (back_item),
        .item_valid  (back_valid),
        .item_ready  (back_ready),
        .valid       (out_valid),
        .ready       (out_ready),
        .kind        (kind),
        .reg_address (reg_address),
        .reg_value   (reg_value),
        .record_end  (record_end)
    );

    // the queue must never report full and empty together
    `RLEPL_ASSERT_IMP(a_queue_status, clk, rst_n, 1'b1, !(q_status.full && q_status.empty))
    // the parser only takes an item when the queue holds one
    `RLEPL_ASSERT_IMP(a_pop_nonempty, clk, rst_n, back_valid && back_ready, !q_status.empty)
    // a rejected word never closes a record
    `RLEPL_ASSERT_IMP(a_reject_no_end, clk, rst_n, out_valid && kind, !record_end)
    // a full queue with a stalled back end holds the input off next cycle
    `RLEPL_ASSERT_NXT(a_full_backpressure, clk, rst_n,
        q_status.full && !back_ready && front_valid && !out_ready, !in_ready)

endmodule

`default_nettype wire
